>>> rtl/md5_pkg.sv
// Shared types, constants and round tables of the MD5 hasher.
package md5_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int POS_W       = $clog2(BLOCK_WORDS);
	// two banks of one block each: fill one while the other is compressed
	localparam int STORE_DEPTH = 2 * BLOCK_WORDS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int ROUNDS      = 64;
	localparam int RND_W       = $clog2(ROUNDS);

	typedef logic [WORD_W-1:0]     word_t;
	typedef logic [3:0][WORD_W-1:0] chain_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [RND_W-1:0]      rnd_t;

	localparam chain_t CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
	localparam word_t  PAD_WORD   = 32'h0000_0080;
	localparam pos_t   LEN_POS    = pos_t'(14);
	localparam pos_t   LAST_POS   = pos_t'(BLOCK_WORDS - 1);
	localparam rnd_t   LAST_RND   = rnd_t'(ROUNDS - 1);

	typedef struct packed {
		logic start;
		logic bank;
		logic chain_init;
	} md5_cmp_ctl_t;

	typedef struct packed {
		logic busy;
		logic bank;
	} md5_cmp_stat_t;

	function automatic word_t md5_rotl(word_t x, logic [4:0] s);
		return (x << s) | (x >> (6'd32 - {1'b0, s}));
	endfunction

	// message word index used by each round
	function automatic pos_t md5_g(rnd_t i);
		pos_t j;
		j = i[3:0];
		unique case (i[5:4])
			2'd0: return j;
			2'd1: return pos_t'(j * 4'd5 + 4'd1);
			2'd2: return pos_t'(j * 4'd3 + 4'd5);
			2'd3: return pos_t'(j * 4'd7);
		endcase
	endfunction

	function automatic logic [4:0] md5_s(rnd_t i);
		unique case ({i[5:4], i[1:0]})
			4'h0: return 5'd7;
			4'h1: return 5'd12;
			4'h2: return 5'd17;
			4'h3: return 5'd22;
			4'h4: return 5'd5;
			4'h5: return 5'd9;
			4'h6: return 5'd14;
			4'h7: return 5'd20;
			4'h8: return 5'd4;
			4'h9: return 5'd11;
			4'hA: return 5'd16;
			4'hB: return 5'd23;
			4'hC: return 5'd6;
			4'hD: return 5'd10;
			4'hE: return 5'd15;
			4'hF: return 5'd21;
		endcase
	endfunction

	function automatic word_t md5_k(rnd_t i);
		unique case (i)
			6'd0:  return 32'hd76aa478;
			6'd1:  return 32'he8c7b756;
			6'd2:  return 32'h242070db;
			6'd3:  return 32'hc1bdceee;
			6'd4:  return 32'hf57c0faf;
			6'd5:  return 32'h4787c62a;
			6'd6:  return 32'ha8304613;
			6'd7:  return 32'hfd469501;
			6'd8:  return 32'h698098d8;
			6'd9:  return 32'h8b44f7af;
			6'd10: return 32'hffff5bb1;
			6'd11: return 32'h895cd7be;
			6'd12: return 32'h6b901122;
			6'd13: return 32'hfd987193;
			6'd14: return 32'ha679438e;
			6'd15: return 32'h49b40821;
			6'd16: return 32'hf61e2562;
			6'd17: return 32'hc040b340;
			6'd18: return 32'h265e5a51;
			6'd19: return 32'he9b6c7aa;
			6'd20: return 32'hd62f105d;
			6'd21: return 32'h02441453;
			6'd22: return 32'hd8a1e681;
			6'd23: return 32'he7d3fbc8;
			6'd24: return 32'h21e1cde6;
			6'd25: return 32'hc33707d6;
			6'd26: return 32'hf4d50d87;
			6'd27: return 32'h455a14ed;
			6'd28: return 32'ha9e3e905;
			6'd29: return 32'hfcefa3f8;
			6'd30: return 32'h676f02d9;
			6'd31: return 32'h8d2a4c8a;
			6'd32: return 32'hfffa3942;
			6'd33: return 32'h8771f681;
			6'd34: return 32'h6d9d6122;
			6'd35: return 32'hfde5380c;
			6'd36: return 32'ha4beea44;
			6'd37: return 32'h4bdecfa9;
			6'd38: return 32'hf6bb4b60;
			6'd39: return 32'hbebfbc70;
			6'd40: return 32'h289b7ec6;
			6'd41: return 32'heaa127fa;
			6'd42: return 32'hd4ef3085;
			6'd43: return 32'h04881d05;
			6'd44: return 32'hd9d4d039;
			6'd45: return 32'he6db99e5;
			6'd46: return 32'h1fa27cf8;
			6'd47: return 32'hc4ac5665;
			6'd48: return 32'hf4292244;
			6'd49: return 32'h432aff97;
			6'd50: return 32'hab9423a7;
			6'd51: return 32'hfc93a039;
			6'd52: return 32'h655b59c3;
			6'd53: return 32'h8f0ccc92;
			6'd54: return 32'hffeff47d;
			6'd55: return 32'h85845dd1;
			6'd56: return 32'h6fa87e4f;
			6'd57: return 32'hfe2ce6e0;
			6'd58: return 32'ha3014314;
			6'd59: return 32'h4e0811a1;
			6'd60: return 32'hf7537e82;
			6'd61: return 32'hbd3af235;
			6'd62: return 32'h2ad7d2bb;
			6'd63: return 32'heb86d391;
		endcase
	endfunction

endpackage

>>> rtl/md5_in_if.sv
// Message word channel: valid/ready handshake with word, byte count and last flag.
interface md5_in_if import md5_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      data_word;
	logic [2:0] valid_bytes;
	logic       last;

	modport source(output valid, data_word, valid_bytes, last, input ready);
	modport sink(input valid, data_word, valid_bytes, last, output ready);
endinterface

>>> rtl/md5_out_if.sv
// Digest word channel: valid/ready handshake with digest word, index and end flag.
interface md5_out_if import md5_pkg::*; ();
	logic       valid;
	logic       ready;
	word_t      digest_word;
	logic [1:0] word_index;
	logic       digest_end;

	modport source(output valid, digest_word, word_index, digest_end, input ready);
	modport sink(input valid, digest_word, word_index, digest_end, output ready);
endinterface

>>> rtl/md5_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/md5_cmp.sv
// MD5 compression engine: one round per cycle over a block held in the block RAM.
module md5_cmp import md5_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  md5_cmp_ctl_t   ctl,
	output md5_cmp_stat_t  stat,
	output chain_t         chain,
	output logic [STORE_AW-1:0] rd_addr,
	input  word_t          rd_data
);
	typedef enum logic [1:0] {CS_IDLE, CS_RUN, CS_FIN} cmp_state_t;

	cmp_state_t state_q;
	chain_t     chain_q;
	logic       bank_q;
	rnd_t       rnd_q;
	word_t      a_q, b_q, c_q, d_q;
	word_t      ka_q;

	rnd_t  rnd_nxt;
	word_t f, t, b_new;

	always_comb begin
		unique case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
		endcase
		rnd_nxt = rnd_q + rnd_t'(1);
		// ka_q already holds K plus the a word for this round
		t       = ka_q + f + rd_data;
		b_new   = b_q + md5_rotl(t, md5_s(rnd_q));
		// fetch the message word of the next round now, so the registered read has it when that round starts
		if (state_q == CS_RUN) begin
			rd_addr = {bank_q, md5_g(rnd_nxt)};
		end else begin
			rd_addr = {ctl.bank, md5_g(rnd_t'(0))};
		end
	end

	assign stat.busy = (state_q != CS_IDLE);
	assign stat.bank = bank_q;
	assign chain     = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			chain_q <= CHAIN_INIT;
			bank_q  <= 1'b0;
			rnd_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
			c_q     <= '0;
			d_q     <= '0;
			ka_q    <= '0;
		end else begin
			unique case (state_q)
				CS_IDLE: begin
					if (ctl.start) begin
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						ka_q    <= md5_k(rnd_t'(0)) + chain_q[0];
						bank_q  <= ctl.bank;
						rnd_q   <= rnd_t'(0);
						state_q <= CS_RUN;
					end else if (ctl.chain_init) begin
						chain_q <= CHAIN_INIT;
					end
				end
				CS_RUN: begin
					a_q   <= d_q;
					b_q   <= b_new;
					c_q   <= b_q;
					d_q   <= c_q;
					ka_q  <= md5_k(rnd_nxt) + d_q;
					rnd_q <= rnd_nxt;
					if (rnd_q == LAST_RND) begin
						state_q <= CS_FIN;
					end
				end
				CS_FIN: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					state_q    <= CS_IDLE;
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/md5_hash_core.sv
// Streaming MD5 hasher top level: block fill, padding, compression and digest output.
//
//   channel | dir | payload                                 | meaning
//   msg     | in  | data_word[31:0] valid_bytes[2:0] last   | message word, LE bytes
//   dig     | out | digest_word[31:0] word_index[1:0] digest_end | digest A..D
//
// A message word is taken on each handshake and written into the fill bank of the block RAM.
// Each full block passes through the compression engine (a load, one RAM read and one
// round per cycle, then the chain update); msg.ready drops while a full block waits for
// the engine. After the last word the pad, zero fill and length words are written one
// per cycle while no full block waits (up to 18), then the four digest words go out,
// held under back pressure on dig.
// Reset is asynchronous; it loads the initial chain and empties the block position.
module md5_hash_core import md5_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	md5_in_if.sink    msg,
	md5_out_if.source dig
);
	typedef enum logic [1:0] {S_IN, S_PAD, S_DRAIN, S_OUT} top_state_t;

	top_state_t    state_q;
	pos_t          pos_q;
	logic          bank_q;
	logic          full_q;
	logic [63:0]   bitlen_q;
	logic          extra_q;
	logic          hi_next_q;
	logic [1:0]    idx_q;

	md5_cmp_ctl_t  cmp_ctl;
	md5_cmp_stat_t cmp_stat;
	chain_t        cmp_chain;
	logic [STORE_AW-1:0] rd_addr;
	word_t         rd_data;

	logic          msg_fire, dig_fire;
	logic [2:0]    n_sat;
	word_t         first_word, pad_word, push_data;
	logic          push_en;

	assign msg.ready = (state_q == S_IN) && !full_q;
	assign msg_fire  = msg.valid && msg.ready;
	assign dig_fire  = dig.valid && dig.ready;

	always_comb begin
		n_sat = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
		// for a partial last word, mask unused bytes and append the pad byte right after the data
		unique case (n_sat)
			3'd0:    first_word = PAD_WORD;
			3'd1:    first_word = {16'h0, PAD_WORD[7:0], msg.data_word[7:0]};
			3'd2:    first_word = {8'h0, PAD_WORD[7:0], msg.data_word[15:0]};
			3'd3:    first_word = {PAD_WORD[7:0], msg.data_word[23:0]};
			default: first_word = msg.data_word;
		endcase
		if (extra_q) begin
			pad_word = PAD_WORD;
		end else if (hi_next_q) begin
			pad_word = bitlen_q[63:32];
		end else if (pos_q == LEN_POS) begin
			pad_word = bitlen_q[31:0];
		end else begin
			pad_word = '0;
		end
		push_en   = msg_fire || ((state_q == S_PAD) && !full_q);
		push_data = (state_q == S_PAD) ? pad_word
		          : (msg.last ? first_word : msg.data_word);
	end

	// the engine only reads the bank that is not being filled
	assign cmp_ctl.start      = full_q && !cmp_stat.busy;
	assign cmp_ctl.bank       = bank_q;
	assign cmp_ctl.chain_init = dig_fire && dig.digest_end;

	md5_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (push_en),
		.waddr ({bank_q, pos_q}),
		.wdata (push_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	md5_cmp u_cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (cmp_ctl),
		.stat    (cmp_stat),
		.chain   (cmp_chain),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign dig.valid       = (state_q == S_OUT);
	assign dig.digest_word = cmp_chain[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.digest_end  = (idx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IN;
			pos_q     <= '0;
			bank_q    <= 1'b0;
			full_q    <= 1'b0;
			bitlen_q  <= '0;
			extra_q   <= 1'b0;
			hi_next_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmp_ctl.start) begin
				full_q <= 1'b0;
				bank_q <= ~bank_q;
			end
			if (push_en) begin
				pos_q <= pos_q + pos_t'(1);
				if (pos_q == LAST_POS) begin
					full_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_IN: begin
					if (msg_fire) begin
						if (msg.last) begin
							bitlen_q  <= bitlen_q + {58'b0, n_sat, 3'b000};
							extra_q   <= (n_sat == 3'd4);
							hi_next_q <= 1'b0;
							state_q   <= S_PAD;
						end else begin
							bitlen_q <= bitlen_q + 64'd32;
						end
					end
				end
				S_PAD: begin
					if (!full_q) begin
						extra_q <= 1'b0;
						if (!extra_q && hi_next_q) begin
							hi_next_q <= 1'b0;
							state_q   <= S_DRAIN;
						end else if (!extra_q && (pos_q == LEN_POS)) begin
							hi_next_q <= 1'b1;
						end
					end
				end
				S_DRAIN: begin
					// wait for the final block to leave the engine
					if (!full_q && !cmp_stat.busy) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (dig_fire) begin
						idx_q <= idx_q + 2'd1;
						if (dig.digest_end) begin
							bitlen_q <= '0;
							state_q  <= S_IN;
						end
					end
				end
				default: state_q <= S_IN;
			endcase
		end
	end

	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (!cmp_stat.busy && !full_q))
		else $error("digest shown while a block is still in flight");

	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_stat.busy && push_en) |-> (bank_q != cmp_stat.bank))
		else $error("write into the bank under compression");

	a_chain_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_fire && dig.digest_end) |=> (cmp_chain == CHAIN_INIT))
		else $error("chain not restored after digest");

	a_pos_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (pos_q == '0))
		else $error("digest with a partial block pending");
endmodule
